FILE: sv/biquad_cascade_filter_assert.svh
// Assertion macros shared by the biquad cascade filter modules.
`ifndef BIQUAD_CASCADE_FILTER_ASSERT_SVH
`define BIQUAD_CASCADE_FILTER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define BQC_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BQC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BQC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bqc_pkg.sv
// Types, constants and control structure of the biquad cascade filter.
package bqc_pkg;

  localparam int MAX_SECTIONS   = 8;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = 20;
  localparam int NUM_COEFS      = 5;
  localparam int DELAY_BITS     = COEF_FRAC_BITS + SAMPLE_BITS + 8;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = DELAY_BITS + 2;
  localparam int ACC2_BITS      = PROD_BITS + 1;

  localparam int CMD_BITS  = 2;
  localparam int SECF_BITS = 3;
  localparam int SEL_BITS  = 3;
  localparam int CFG_BITS  = 4;

  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
  localparam int COEF_DEPTH = NUM_COEFS * MAX_SECTIONS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int DLY_DEPTH  = 2 * MAX_SECTIONS;
  localparam int DLY_AW     = SEC_W + 1;

  localparam int SEC_LSB       = SAMPLE_BITS;
  localparam int SEL_LSB       = SEC_LSB + SECF_BITS;
  localparam int VAL_LSB       = SEL_LSB + SEL_BITS;
  localparam int IN_FIELD_BITS = VAL_LSB + COEF_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_FILTER = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [SEL_BITS-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_Z_RND,
    ACC_ADD_P,
    ACC_LOAD_Z_P,
    ACC_SUB_P
  } acc_op_t;

  typedef enum logic [1:0] {
    ACC2_HOLD,
    ACC2_LOAD_P,
    ACC2_SUB_P
  } acc2_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_P0,
    ST_P1,
    ST_Y,
    ST_A1,
    ST_A2,
    ST_WZ1,
    ST_WZ2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             coef_wr;
    logic             dly_clr;
    logic             coef_rd;
    coef_sel_t        coef_sel;
    logic             dly_rd;
    logic             dly_wr;
    logic             dly_hi;
    logic             mul_en;
    logic             mul_y;
    acc_op_t          acc_op;
    acc2_op_t         acc2_op;
    logic             y_load;
    logic             x_next;
    logic             out_load;
    logic [SEC_W-1:0] sec;
  } ctl_t;

endpackage

FILE: sv/bqc_datapath.sv
// Datapath of the biquad cascade: coefficient and delay stores, shared multiplier, accumulators.
`include "biquad_cascade_filter_assert.svh"

module bqc_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bqc_pkg::ctl_t                          ctl,
  input  logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic [bqc_pkg::SECF_BITS-1:0]          section_index,
  input  logic [bqc_pkg::SEL_BITS-1:0]           coefficient_select,
  input  logic signed [bqc_pkg::COEF_BITS-1:0]   coefficient_value,
  output logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                   saturated
);

  localparam logic signed [bqc_pkg::ACC_BITS-1:0] RND =
    bqc_pkg::ACC_BITS'(1) <<< (bqc_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [bqc_pkg::ACC_BITS-1:0] Y_MAX =
    (bqc_pkg::ACC_BITS'(1) <<< (bqc_pkg::SAMPLE_BITS - 1)) - bqc_pkg::ACC_BITS'(1);
  localparam logic signed [bqc_pkg::ACC_BITS-1:0] Y_MIN = -Y_MAX - bqc_pkg::ACC_BITS'(1);
  localparam logic signed [bqc_pkg::ACC_BITS-1:0] Z_MAX =
    (bqc_pkg::ACC_BITS'(1) <<< (bqc_pkg::DELAY_BITS - 1)) - bqc_pkg::ACC_BITS'(1);
  localparam logic signed [bqc_pkg::ACC_BITS-1:0] Z_MIN = -Z_MAX - bqc_pkg::ACC_BITS'(1);

  logic signed [bqc_pkg::COEF_BITS-1:0]   coef_mem [bqc_pkg::COEF_DEPTH];
  logic [bqc_pkg::COEF_DEPTH-1:0]         coef_vld_r;
  logic signed [bqc_pkg::COEF_BITS-1:0]   coef_rd_r;
  logic                                   coef_rd_vld_r;
  logic signed [bqc_pkg::DELAY_BITS-1:0]  dly_mem [bqc_pkg::DLY_DEPTH];
  logic [bqc_pkg::DLY_DEPTH-1:0]          dly_vld_r;
  logic signed [bqc_pkg::DELAY_BITS-1:0]  dly_rd_r;
  logic                                   dly_rd_vld_r;

  logic signed [bqc_pkg::SAMPLE_BITS-1:0] x_r;
  logic signed [bqc_pkg::SAMPLE_BITS-1:0] y_r;
  logic                                   flag_r;
  logic signed [bqc_pkg::PROD_BITS-1:0]   prod_r;
  logic signed [bqc_pkg::ACC_BITS-1:0]    acc_r;
  logic signed [bqc_pkg::ACC_BITS-1:0]    acc_nxt;
  logic signed [bqc_pkg::ACC2_BITS-1:0]   acc2_r;
  logic signed [bqc_pkg::ACC2_BITS-1:0]   acc2_nxt;
  logic signed [bqc_pkg::SAMPLE_BITS-1:0] out_data_r;
  logic                                   out_sat_r;

  logic [bqc_pkg::COEF_AW-1:0]            coef_wa;
  logic [bqc_pkg::COEF_AW-1:0]            coef_ra;
  logic [bqc_pkg::DLY_AW-1:0]             dly_a;
  logic                                   coef_wr_ok;
  logic signed [bqc_pkg::COEF_BITS-1:0]   coef_q;
  logic signed [bqc_pkg::DELAY_BITS-1:0]  z_q;
  logic signed [bqc_pkg::SAMPLE_BITS-1:0] mul_b;
  logic signed [bqc_pkg::ACC_BITS-1:0]    acc_sh;
  logic signed [bqc_pkg::SAMPLE_BITS-1:0] y_clip;
  logic                                   y_hit;
  logic signed [bqc_pkg::DELAY_BITS-1:0]  z1_clip;
  logic signed [bqc_pkg::DELAY_BITS-1:0]  dly_wdata;

  assign coef_wa = bqc_pkg::COEF_AW'(bqc_pkg::NUM_COEFS) * bqc_pkg::COEF_AW'(section_index)
                 + bqc_pkg::COEF_AW'(coefficient_select);
  assign coef_ra = bqc_pkg::COEF_AW'(bqc_pkg::NUM_COEFS) * bqc_pkg::COEF_AW'(ctl.sec)
                 + bqc_pkg::COEF_AW'(ctl.coef_sel);
  assign dly_a   = {ctl.sec, ctl.dly_hi};

  assign coef_wr_ok = ctl.coef_wr && (int'(section_index) < bqc_pkg::MAX_SECTIONS)
                      && (int'(coefficient_select) < bqc_pkg::NUM_COEFS);

  // Entries never written since reset read as zero; delay entries also read as zero until written after the last clear.
  assign coef_q = coef_rd_vld_r ? coef_rd_r : '0;
  assign z_q    = dly_rd_vld_r ? dly_rd_r : '0;
  assign mul_b  = ctl.mul_y ? y_r : x_r;

  always_comb begin
    acc_sh = acc_r >>> bqc_pkg::COEF_FRAC_BITS;
    y_hit  = 1'b0;
    if (acc_sh > Y_MAX) begin
      y_clip = {1'b0, {(bqc_pkg::SAMPLE_BITS - 1){1'b1}}};
      y_hit  = 1'b1;
    end else if (acc_sh < Y_MIN) begin
      y_clip = {1'b1, {(bqc_pkg::SAMPLE_BITS - 1){1'b0}}};
      y_hit  = 1'b1;
    end else begin
      y_clip = acc_sh[bqc_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (acc_r > Z_MAX) begin
      z1_clip = {1'b0, {(bqc_pkg::DELAY_BITS - 1){1'b1}}};
    end else if (acc_r < Z_MIN) begin
      z1_clip = {1'b1, {(bqc_pkg::DELAY_BITS - 1){1'b0}}};
    end else begin
      z1_clip = acc_r[bqc_pkg::DELAY_BITS-1:0];
    end
  end

  assign dly_wdata = ctl.dly_hi ? bqc_pkg::DELAY_BITS'(acc2_r) : z1_clip;

  always_comb begin
    case (ctl.acc_op)
      bqc_pkg::ACC_LOAD_Z_RND: acc_nxt = bqc_pkg::ACC_BITS'(z_q) + RND;
      bqc_pkg::ACC_ADD_P:      acc_nxt = acc_r + bqc_pkg::ACC_BITS'(prod_r);
      bqc_pkg::ACC_LOAD_Z_P:   acc_nxt = bqc_pkg::ACC_BITS'(z_q) + bqc_pkg::ACC_BITS'(prod_r);
      bqc_pkg::ACC_SUB_P:      acc_nxt = acc_r - bqc_pkg::ACC_BITS'(prod_r);
      default:                 acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    case (ctl.acc2_op)
      bqc_pkg::ACC2_LOAD_P: acc2_nxt = bqc_pkg::ACC2_BITS'(prod_r);
      bqc_pkg::ACC2_SUB_P:  acc2_nxt = acc2_r - bqc_pkg::ACC2_BITS'(prod_r);
      default:              acc2_nxt = acc2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_wr_ok) begin
      coef_mem[coef_wa] <= coefficient_value;
    end
    if (ctl.coef_rd) begin
      coef_rd_r <= coef_mem[coef_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dly_wr) begin
      dly_mem[dly_a] <= dly_wdata;
    end
    if (ctl.dly_rd) begin
      dly_rd_r <= dly_mem[dly_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r    <= '0;
      coef_rd_vld_r <= 1'b0;
      dly_vld_r     <= '0;
      dly_rd_vld_r  <= 1'b0;
    end else begin
      if (coef_wr_ok) begin
        coef_vld_r[coef_wa] <= 1'b1;
      end
      if (ctl.coef_rd) begin
        coef_rd_vld_r <= coef_vld_r[coef_ra];
      end
      if (ctl.dly_clr) begin
        dly_vld_r <= '0;
      end else if (ctl.dly_wr) begin
        dly_vld_r[dly_a] <= 1'b1;
      end
      if (ctl.dly_rd) begin
        dly_rd_vld_r <= dly_vld_r[dly_a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r    <= sample_in;
      flag_r <= 1'b0;
    end else if (ctl.x_next) begin
      x_r <= y_r;
    end
    if (ctl.y_load) begin
      y_r <= y_clip;
      if (y_hit) begin
        flag_r <= 1'b1;
      end
    end
    if (ctl.mul_en) begin
      prod_r <= coef_q * mul_b;
    end
    acc_r  <= acc_nxt;
    acc2_r <= acc2_nxt;
    if (ctl.out_load) begin
      out_data_r <= x_r;
      out_sat_r  <= flag_r;
    end
  end

  assign sample_out = out_data_r;
  assign saturated  = out_sat_r;

  `BQC_ASSERT_HOLDS(a_dly_single_port, !(ctl.dly_wr && ctl.dly_rd), "delay store read and written in one cycle")
  `BQC_ASSERT_HOLDS(a_cmd_exclusive, $onehot0({ctl.coef_wr, ctl.dly_clr, ctl.start, ctl.mul_en}), "conflicting datapath commands")

endmodule

FILE: sv/bqc_ctrl.sv
// Controller of the biquad cascade: request handshake, configuration register and section sequencer.
`include "biquad_cascade_filter_assert.svh"

module bqc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  bqc_pkg::cmd_t                in_cmd,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bqc_pkg::CFG_BITS-1:0] cfg_data,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output bqc_pkg::ctl_t                ctl
);

  bqc_pkg::state_t              state_r;
  bqc_pkg::state_t              state_nxt;
  logic [bqc_pkg::SEC_W-1:0]    sec_r;
  logic [bqc_pkg::SEC_W-1:0]    sec_nxt;
  logic [bqc_pkg::CFG_BITS-1:0] act_r;
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  logic [bqc_pkg::CNT_W-1:0]    n_eff;
  logic                         last_sec;
  logic                         in_req;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == bqc_pkg::ST_IDLE);
  assign in_req     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;

  // A section count above the number of built sections acts as all of them.
  assign n_eff    = (int'(act_r) > bqc_pkg::MAX_SECTIONS) ?
                    bqc_pkg::CNT_W'(bqc_pkg::MAX_SECTIONS) : bqc_pkg::CNT_W'(act_r);
  assign last_sec = (bqc_pkg::CNT_W'(sec_r) + bqc_pkg::CNT_W'(1)) == n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bqc_pkg::ST_IDLE;
      sec_r     <= '0;
      act_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sec_r     <= sec_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        act_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    ctl       = '0;
    ctl.sec   = sec_r;
    case (state_r)
      bqc_pkg::ST_IDLE: begin
        sec_nxt = '0;
        if (in_req) begin
          case (in_cmd)
            bqc_pkg::CMD_FILTER: begin
              ctl.start = 1'b1;
              state_nxt = (n_eff == '0) ? bqc_pkg::ST_OUT : bqc_pkg::ST_RD;
            end
            bqc_pkg::CMD_COEF:  ctl.coef_wr = 1'b1;
            bqc_pkg::CMD_CLEAR: ctl.dly_clr = 1'b1;
            default: ;
          endcase
        end
      end
      bqc_pkg::ST_RD: begin
        ctl.coef_rd  = 1'b1;
        ctl.coef_sel = bqc_pkg::COEF_B0;
        ctl.dly_rd   = 1'b1;
        state_nxt    = bqc_pkg::ST_P0;
      end
      bqc_pkg::ST_P0: begin
        ctl.mul_en   = 1'b1;
        ctl.acc_op   = bqc_pkg::ACC_LOAD_Z_RND;
        ctl.coef_rd  = 1'b1;
        ctl.coef_sel = bqc_pkg::COEF_B1;
        ctl.dly_rd   = 1'b1;
        ctl.dly_hi   = 1'b1;
        state_nxt    = bqc_pkg::ST_P1;
      end
      bqc_pkg::ST_P1: begin
        ctl.mul_en   = 1'b1;
        ctl.acc_op   = bqc_pkg::ACC_ADD_P;
        ctl.coef_rd  = 1'b1;
        ctl.coef_sel = bqc_pkg::COEF_B2;
        state_nxt    = bqc_pkg::ST_Y;
      end
      bqc_pkg::ST_Y: begin
        ctl.y_load   = 1'b1;
        ctl.mul_en   = 1'b1;
        ctl.acc_op   = bqc_pkg::ACC_LOAD_Z_P;
        ctl.coef_rd  = 1'b1;
        ctl.coef_sel = bqc_pkg::COEF_A1;
        state_nxt    = bqc_pkg::ST_A1;
      end
      bqc_pkg::ST_A1: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_y    = 1'b1;
        ctl.acc2_op  = bqc_pkg::ACC2_LOAD_P;
        ctl.coef_rd  = 1'b1;
        ctl.coef_sel = bqc_pkg::COEF_A2;
        state_nxt    = bqc_pkg::ST_A2;
      end
      bqc_pkg::ST_A2: begin
        ctl.mul_en = 1'b1;
        ctl.mul_y  = 1'b1;
        ctl.acc_op = bqc_pkg::ACC_SUB_P;
        state_nxt  = bqc_pkg::ST_WZ1;
      end
      bqc_pkg::ST_WZ1: begin
        ctl.dly_wr  = 1'b1;
        ctl.acc2_op = bqc_pkg::ACC2_SUB_P;
        state_nxt   = bqc_pkg::ST_WZ2;
      end
      bqc_pkg::ST_WZ2: begin
        ctl.dly_wr = 1'b1;
        ctl.dly_hi = 1'b1;
        ctl.x_next = 1'b1;
        if (last_sec) begin
          state_nxt = bqc_pkg::ST_OUT;
        end else begin
          sec_nxt   = sec_r + bqc_pkg::SEC_W'(1);
          state_nxt = bqc_pkg::ST_RD;
        end
      end
      bqc_pkg::ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          ctl.out_load = 1'b1;
          state_nxt    = bqc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bqc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  `BQC_ASSERT_IMPLIES(a_out_no_overwrite, ctl.out_load, (!out_vld_r || out_tready), "result register overwritten before it was taken")
  `BQC_ASSERT_IMPLIES(a_sec_in_range, (state_r != bqc_pkg::ST_IDLE && state_r != bqc_pkg::ST_OUT), (bqc_pkg::CNT_W'(sec_r) < n_eff), "section counter beyond active sections")
  `BQC_ASSERT_NEXT(a_bypass, (in_req && in_cmd == bqc_pkg::CMD_FILTER && n_eff == '0), (state_r == bqc_pkg::ST_OUT), "sample with no active sections did not bypass")

endmodule

FILE: sv/biquad_cascade_filter.sv
// Top level of the biquad cascade filter.
// A request carries a command in in_tuser: a sample to filter, a coefficient write, a
// clear of all delay elements or no operation. A sample passes through the first
// n = min(active_sections, 8) second-order sections, using one shared 20x16 multiplier;
// each section forms the feed-forward and feedback products and writes both delay
// elements back. The result is loaded into the output register, and the next request
// can be taken in the cycle after; with n = 0 the sample passes unchanged. A sample whose
// result finds the output register still full waits until that result is taken.
// Coefficient writes and clears are done in idle. The next request is accepted
// as soon as the sequencer is back in idle, even while the last result still waits to
// be taken. Coefficients and delay elements read as zero after reset, and the section
// count may only be written while no request is in progress.
module biquad_cascade_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_in[15:0], section_index[18:16], coefficient_select[21:19],
  // coefficient_value[41:22], zero fill above
  input  logic [bqc_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // command[1:0]
  input  logic [bqc_pkg::CMD_BITS-1:0]      in_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bqc_pkg::CFG_BITS-1:0]      cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sample_out[15:0]
  output logic [bqc_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // saturated[0]
  output logic                              out_tuser
);

  bqc_pkg::ctl_t                          ctl;
  bqc_pkg::cmd_t                          in_cmd;
  logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_in;
  logic [bqc_pkg::SECF_BITS-1:0]          section_index;
  logic [bqc_pkg::SEL_BITS-1:0]           coefficient_select;
  logic signed [bqc_pkg::COEF_BITS-1:0]   coefficient_value;
  logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   saturated;

  assign in_cmd             = bqc_pkg::cmd_t'(in_tuser);
  assign sample_in          = in_tdata[bqc_pkg::SEC_LSB-1:0];
  assign section_index      = in_tdata[bqc_pkg::SEL_LSB-1:bqc_pkg::SEC_LSB];
  assign coefficient_select = in_tdata[bqc_pkg::VAL_LSB-1:bqc_pkg::SEL_LSB];
  assign coefficient_value  = in_tdata[bqc_pkg::IN_FIELD_BITS-1:bqc_pkg::VAL_LSB];

  assign out_tdata = bqc_pkg::OUT_DATA_BITS'($unsigned(sample_out));
  assign out_tuser = saturated;

  bqc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_cmd),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  bqc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sample_in          (sample_in),
    .section_index      (section_index),
    .coefficient_select (coefficient_select),
    .coefficient_value  (coefficient_value),
    .sample_out         (sample_out),
    .saturated          (saturated)
  );

endmodule
